// File: rtl/lav_pkg.sv
// Shared constants and types for the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;
  localparam int DEF_FRAC_BITS = 16;
  localparam int COORD_W       = 32;
  localparam int DIFF_W        = 33;
  localparam int UNIT_W        = 18;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
endpackage

// File: rtl/lav_pose_if.sv
// Pose channel: eye, target and up vector with valid/ready.
`timescale 1ns / 1ps
interface lav_pose_if;
  logic valid;
  logic ready;
  lav_pkg::coord_t eye_x, eye_y, eye_z;
  lav_pkg::coord_t target_x, target_y, target_z;
  lav_pkg::coord_t up_x, up_y, up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

// File: rtl/lav_view_if.sv
// View channel: upper three rows of the view matrix with valid/ready.
`timescale 1ns / 1ps
interface lav_view_if;
  logic valid;
  logic ready;
  lav_pkg::unit_t side_x, side_y, side_z;
  lav_pkg::unit_t upaxis_x, upaxis_y, upaxis_z;
  lav_pkg::unit_t back_x, back_y, back_z;
  lav_pkg::coord_t shift_x, shift_y, shift_z;

  modport source (output valid, side_x, side_y, side_z, upaxis_x, upaxis_y, upaxis_z,
                  back_x, back_y, back_z, shift_x, shift_y, shift_z, input ready);
  modport sink (input valid, side_x, side_y, side_z, upaxis_x, upaxis_y, upaxis_z,
                back_x, back_y, back_z, shift_x, shift_y, shift_z, output ready);
endinterface

// File: rtl/lav_delay.sv
// Enable-gated shift register that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps
module lav_delay #(
  parameter int W     = 32,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];
endmodule

// File: rtl/lav_norm.sv
// Pipelined exact normalizer: squares, sum, then one quotient bit per stage.
`timescale 1ns / 1ps
module lav_norm #(
  parameter int MW        = 33,
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [MW:0]          vin  [3],
  output logic signed [FRAC_BITS+1:0] unit [3]
);
  localparam int HW = MW - 32;
  localparam int SW = 2 * MW + 2;
  localparam int LW = 2 * FRAC_BITS + 4 + SW;
  localparam int QW = FRAC_BITS + 1;
  localparam int NS = FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;

  logic [MW-1:0]     mag_a [3];
  logic              neg_a [3];
  logic [63:0]       ll_b  [3];
  logic [HW+31:0]    hl_b  [3];
  logic [2*HW-1:0]   hh_b  [3];
  logic              neg_b [3];
  logic [2*MW-1:0]   sq_c  [3];
  logic              neg_c [3];

  logic [2*MW-1:0] sq_s   [0:NS][3];
  logic            neg_s  [0:NS][3];
  logic [QW-1:0]   q_s    [0:NS][3];
  logic [LW-1:0]   a1_s   [0:NS][3];
  logic [LW-1:0]   a2_s   [0:NS][3];
  logic [SW-1:0]   sum_s  [0:NS];
  logic            zero_s [0:NS];

  // magnitude, partial products, square, sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a[i] <= vin[i][MW] ? MW'(-vin[i]) : MW'(vin[i]);
        neg_a[i] <= vin[i][MW];
        ll_b[i]  <= mag_a[i][31:0] * mag_a[i][31:0];
        hl_b[i]  <= mag_a[i][MW-1:32] * mag_a[i][31:0];
        hh_b[i]  <= mag_a[i][MW-1:32] * mag_a[i][MW-1:32];
        neg_b[i] <= neg_a[i];
        sq_c[i]  <= (2*MW)'(ll_b[i]) + ((2*MW)'(hl_b[i]) << 33) + ((2*MW)'(hh_b[i]) << 64);
        neg_c[i] <= neg_b[i];
        sq_s[0][i]  <= sq_c[i];
        neg_s[0][i] <= neg_c[i];
        q_s[0][i]   <= '0;
        a1_s[0][i]  <= '0;
        a2_s[0][i]  <= '0;
      end
      sum_s[0]  <= SW'(sq_c[0]) + SW'(sq_c[1]) + SW'(sq_c[2]);
      zero_s[0] <= (sq_c[0] == '0) && (sq_c[1] == '0) && (sq_c[2] == '0);
    end
  end

  // Trial a' = 2q + 2^(k+1); keep a*S and a^2*S so (a'-1)^2*S needs only shifts and adds.
  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int K = FRAC_BITS - j;
    logic [LW+1:0] c1  [3];
    logic [LW+1:0] c2  [3];
    logic [LW+1:0] lhs [3];
    logic [LW+1:0] rhs [3];
    logic          ok  [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        c1[i]  = (LW+2)'(a1_s[j][i]) + ((LW+2)'(sum_s[j]) << (K + 1));
        c2[i]  = (LW+2)'(a2_s[j][i]) + ((LW+2)'(a1_s[j][i]) << (K + 2))
                 + ((LW+2)'(sum_s[j]) << (2 * K + 2));
        lhs[i] = c2[i] - (c1[i] << 1) + (LW+2)'(sum_s[j]);
        rhs[i] = (LW+2)'(sq_s[j][i]) << (2 * FRAC_BITS + 2);
        ok[i]  = lhs[i] <= rhs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          sq_s[j+1][i]  <= sq_s[j][i];
          neg_s[j+1][i] <= neg_s[j][i];
          if (ok[i]) begin
            q_s[j+1][i]  <= q_s[j][i] | (QW'(1) << K);
            a1_s[j+1][i] <= c1[i][LW-1:0];
            a2_s[j+1][i] <= c2[i][LW-1:0];
          end else begin
            q_s[j+1][i]  <= q_s[j][i];
            a1_s[j+1][i] <= a1_s[j][i];
            a2_s[j+1][i] <= a2_s[j][i];
          end
        end
        sum_s[j+1]  <= sum_s[j];
        zero_s[j+1] <= zero_s[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_s[NS])         unit[i] <= '0;
        else if (neg_s[NS][i])  unit[i] <= -UW'(q_s[NS][i]);
        else                    unit[i] <= UW'(q_s[NS][i]);
      end
    end
  end
endmodule

// File: rtl/lav_cross.sv
// Two-stage cross product: products, then differences.
`timescale 1ns / 1ps
module lav_cross #(
  parameter int AW = 18,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a [3],
  input  logic signed [BW-1:0]    b [3],
  output logic signed [AW+BW:0]   r [3]
);
  logic signed [AW+BW-1:0] p [6];

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= a[1] * b[2];
      p[1] <= a[2] * b[1];
      p[2] <= a[2] * b[0];
      p[3] <= a[0] * b[2];
      p[4] <= a[0] * b[1];
      p[5] <= a[1] * b[0];
      for (int i = 0; i < 3; i++)
        r[i] <= (AW+BW+1)'(p[2*i]) - (AW+BW+1)'(p[2*i+1]);
    end
  end
endmodule

// File: rtl/lav_dot.sv
// Two-stage dot product with eye, rounded, optionally negated, saturated to 32 bits.
`timescale 1ns / 1ps
module lav_dot #(
  parameter int AW        = 18,
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS,
  parameter bit NEG       = 1'b1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [AW-1:0]  a [3],
  input  lav_pkg::coord_t       b [3],
  output lav_pkg::coord_t       res
);
  localparam int PW = AW + lav_pkg::COORD_W;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] p [3];
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        mag;
  logic [SW-1:0]        rnd;
  logic                 neg;

  always_comb begin
    sum = SW'(p[0]) + SW'(p[1]) + SW'(p[2]);
    mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
    rnd = (mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    neg = sum[SW-1] ^ NEG;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p[i] <= a[i] * b[i];
      if (!neg && rnd > SW'(32'h7fff_ffff))     res <= 32'sh7fff_ffff;
      else if (neg && rnd > SW'(33'h0_8000_0000)) res <= 32'sh8000_0000;
      else if (neg)                             res <= -32'(rnd);
      else                                      res <= 32'(rnd);
    end
  end
endmodule

// File: rtl/look_at_view_matrix.sv
// Top level: right-handed look-at view matrix pipeline.
//
//  channel  dir  payload                                        handshake
//  pose     in   eye, target, up (9 x signed Q16.16)            valid/ready
//  view     out  side, upaxis, back (9 x 18b), shift (3 x 32b)  valid/ready
//
// One pose per cycle unless a held output stalls the pipeline; the two normalizers
// each spend one stage per quotient bit.
// Synchronous reset clears the valid bits and the output valid; the payload is not reset.
// A held output stalls the whole pipeline only while its last stage also holds
// a result; otherwise poses keep flowing into the empty slots.
`timescale 1ns / 1ps
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  lav_pose_if.sink    pose,
  lav_view_if.source  view
);
  localparam int CW   = lav_pkg::COORD_W;
  localparam int DW   = lav_pkg::DIFF_W;
  localparam int OW   = lav_pkg::UNIT_W;
  localparam int FW   = FRAC_BITS + 2;
  localparam int NLAT = FRAC_BITS + 6;
  localparam int XW   = FW + CW + 1;
  localparam int SMW  = FRAC_BITS + 33;
  localparam int UW   = 2 * FW + 1;
  localparam int VL   = 2 * NLAT + 8;

  logic          en;
  logic [VL-1:0] vld;
  logic          o_valid;

  logic signed [DW-1:0] d0 [3];
  logic [3*CW-1:0]      eye0, up0, eye1, up1, eye2, eye3, eye4, eye5;
  logic [3*FW-1:0]      f2p, f3p, f4p, f5p, f7p, s4p, s5p, s7p, u7p;

  logic signed [DW:0]     din_f [3];
  logic signed [FW-1:0]   f_n   [3];
  lav_pkg::coord_t        up1_v [3];
  logic signed [XW-1:0]   c_raw [3];
  logic signed [SMW:0]    din_s [3];
  logic signed [FW-1:0]   s_n   [3];
  logic signed [FW-1:0]   f3_v  [3];
  logic signed [UW-1:0]   u_raw [3];
  logic signed [FW-1:0]   u5    [3];
  logic signed [FW-1:0]   s5_v  [3];
  logic signed [FW-1:0]   f5_v  [3];
  lav_pkg::coord_t        eye5_v [3];
  logic signed [FW-1:0]   s7_v  [3];
  logic signed [FW-1:0]   u7_v  [3];
  logic signed [FW-1:0]   f7_v  [3];
  logic signed [FW:0]     nf7   [3];
  lav_pkg::coord_t        sh_x, sh_y, sh_z;
  logic [UW-1:0]          umag  [3];
  logic [UW-1:0]          urnd  [3];
  logic [UW-1:0]          ucl   [3];

  assign en         = !(vld[VL-1] && o_valid && !view.ready);
  assign pose.ready = en;
  assign view.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[VL-2:0], pose.valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0[0] <= DW'(pose.target_x) - DW'(pose.eye_x);
      d0[1] <= DW'(pose.target_y) - DW'(pose.eye_y);
      d0[2] <= DW'(pose.target_z) - DW'(pose.eye_z);
      eye0  <= {pose.eye_z, pose.eye_y, pose.eye_x};
      up0   <= {pose.up_z, pose.up_y, pose.up_x};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign din_f[i]  = (DW+1)'(d0[i]);
    assign up1_v[i]  = $signed(up1[CW*i +: CW]);
    assign din_s[i]  = (SMW+1)'(c_raw[i]);
    assign f3_v[i]   = $signed(f3p[FW*i +: FW]);
    assign s5_v[i]   = $signed(s5p[FW*i +: FW]);
    assign f5_v[i]   = $signed(f5p[FW*i +: FW]);
    assign eye5_v[i] = $signed(eye5[CW*i +: CW]);
    assign s7_v[i]   = $signed(s7p[FW*i +: FW]);
    assign u7_v[i]   = $signed(u7p[FW*i +: FW]);
    assign f7_v[i]   = $signed(f7p[FW*i +: FW]);
    assign nf7[i]    = -(FW+1)'(f7_v[i]);
    // round the true-up axis back to Q format and clamp to one
    assign umag[i]   = u_raw[i][UW-1] ? UW'(-u_raw[i]) : UW'(u_raw[i]);
    assign urnd[i]   = (umag[i] + (UW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign ucl[i]    = (urnd[i] > (UW'(1) << FRAC_BITS)) ? (UW'(1) << FRAC_BITS) : urnd[i];
  end

  lav_norm #(.MW(DW), .FRAC_BITS(FRAC_BITS)) u_norm_f (
    .clk(clk), .en(en), .vin(din_f), .unit(f_n));

  lav_delay #(.W(6*CW), .DEPTH(NLAT)) u_dly_eu (
    .clk(clk), .en(en), .din({up0, eye0}), .dout({up1, eye1}));

  lav_cross #(.AW(FW), .BW(CW)) u_cross_s (
    .clk(clk), .en(en), .a(f_n), .b(up1_v), .r(c_raw));

  lav_delay #(.W(3*FW + 3*CW), .DEPTH(2)) u_dly_c (
    .clk(clk), .en(en), .din({f_n[2], f_n[1], f_n[0], eye1}), .dout({f2p, eye2}));

  lav_norm #(.MW(SMW), .FRAC_BITS(FRAC_BITS)) u_norm_s (
    .clk(clk), .en(en), .vin(din_s), .unit(s_n));

  lav_delay #(.W(3*FW + 3*CW), .DEPTH(NLAT)) u_dly_s (
    .clk(clk), .en(en), .din({f2p, eye2}), .dout({f3p, eye3}));

  lav_cross #(.AW(FW), .BW(FW)) u_cross_u (
    .clk(clk), .en(en), .a(s_n), .b(f3_v), .r(u_raw));

  lav_delay #(.W(6*FW + 3*CW), .DEPTH(2)) u_dly_u (
    .clk(clk), .en(en), .din({s_n[2], s_n[1], s_n[0], f3p, eye3}),
    .dout({s4p, f4p, eye4}));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) u5[i] <= u_raw[i][UW-1] ? -FW'(ucl[i]) : FW'(ucl[i]);
      s5p  <= s4p;
      f5p  <= f4p;
      eye5 <= eye4;
    end
  end

  lav_dot #(.AW(FW), .FRAC_BITS(FRAC_BITS), .NEG(1'b1)) u_dot_s (
    .clk(clk), .en(en), .a(s5_v), .b(eye5_v), .res(sh_x));
  lav_dot #(.AW(FW), .FRAC_BITS(FRAC_BITS), .NEG(1'b1)) u_dot_u (
    .clk(clk), .en(en), .a(u5), .b(eye5_v), .res(sh_y));
  lav_dot #(.AW(FW), .FRAC_BITS(FRAC_BITS), .NEG(1'b0)) u_dot_f (
    .clk(clk), .en(en), .a(f5_v), .b(eye5_v), .res(sh_z));

  lav_delay #(.W(9*FW), .DEPTH(2)) u_dly_o (
    .clk(clk), .en(en), .din({s5p, u5[2], u5[1], u5[0], f5p}), .dout({s7p, u7p, f7p}));

  // output register: take the last stage whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (!o_valid || view.ready) o_valid <= vld[VL-1];
  end

  always_ff @(posedge clk) begin
    if ((!o_valid || view.ready) && vld[VL-1]) begin
      view.side_x   <= OW'(s7_v[0]);
      view.side_y   <= OW'(s7_v[1]);
      view.side_z   <= OW'(s7_v[2]);
      view.upaxis_x <= OW'(u7_v[0]);
      view.upaxis_y <= OW'(u7_v[1]);
      view.upaxis_z <= OW'(u7_v[2]);
      view.back_x   <= OW'(nf7[0]);
      view.back_y   <= OW'(nf7[1]);
      view.back_z   <= OW'(nf7[2]);
      view.shift_x  <= sh_x;
      view.shift_y  <= sh_y;
      view.shift_z  <= sh_z;
    end
  end
endmodule

// File: rtl/lav_checker.sv
// Port-level checks on the view channel, bound to the top level.
`timescale 1ns / 1ps
module lav_checker #(
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS
) (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input lav_pkg::unit_t  side_x, side_y, side_z,
  input lav_pkg::unit_t  upaxis_x, upaxis_y, upaxis_z,
  input lav_pkg::unit_t  back_x, back_y, back_z,
  input lav_pkg::coord_t shift_x
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("view valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(shift_x) && $stable(side_x))
    else $error("view payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("view valid right after reset");

  if (FRAC_BITS <= 16) begin : g_unit
    a_back_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> ($signed(back_x) <= (1 << FRAC_BITS)) && ($signed(back_x) >= -(1 << FRAC_BITS))
                 && ($signed(back_y) <= (1 << FRAC_BITS)) && ($signed(back_y) >= -(1 << FRAC_BITS)))
      else $error("back axis beyond unit length");

    a_zero_forward: assert property (@(posedge clk) disable iff (rst)
      out_valid && back_x == '0 && back_y == '0 && back_z == '0
      |-> side_x == '0 && side_y == '0 && side_z == '0
          && upaxis_x == '0 && upaxis_y == '0 && upaxis_z == '0)
      else $error("nonzero axes from a zero forward axis");
  end
endmodule

bind look_at_view_matrix lav_checker #(.FRAC_BITS(FRAC_BITS)) u_lav_checker (
  .clk(clk), .rst(rst), .out_valid(view.valid), .out_ready(view.ready),
  .side_x(view.side_x), .side_y(view.side_y), .side_z(view.side_z),
  .upaxis_x(view.upaxis_x), .upaxis_y(view.upaxis_y), .upaxis_z(view.upaxis_z),
  .back_x(view.back_x), .back_y(view.back_y), .back_z(view.back_z),
  .shift_x(view.shift_x));

// File: dv/look_at_view_matrix_checker.sv
// Checker for the look-at view matrix block: predicts each view from its pose and compares.
`timescale 1ns / 1ps
module look_at_view_matrix_checker #(
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  lav_pose_if         pose,
  lav_view_if         view,
  output int          fail_count,
  output int          views_pending
);
  typedef struct {
    lav_pkg::unit_t  unit_field [9];
    lav_pkg::coord_t shift      [3];
  } view_rows_t;

  view_rows_t view_queue[$];

  string unit_names [9] = '{"side_x", "side_y", "side_z", "upaxis_x", "upaxis_y",
                            "upaxis_z", "back_x", "back_y", "back_z"};
  string shift_names [3] = '{"shift_x", "shift_y", "shift_z"};

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Divide by 2^FRAC_BITS, rounding to nearest with ties away from zero.
  function automatic longint round_frac(input longint v);
    logic [63:0] r;
    r = (magnitude(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact nearest unit vector, found by bisection on each component.
  function automatic void unit_vector(input longint v [3], output longint o [3]);
    logic [191:0] sum_sq, comp_sq, lhs, rhs;
    logic [63:0]  m, odd;
    longint       lo, hi, mid;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      m = magnitude(v[i]);
      comp_sq = m * m;
      sum_sq += comp_sq;
    end
    for (int i = 0; i < 3; i++) begin
      o[i] = 0;
      if (sum_sq != 0) begin
        m = magnitude(v[i]);
        comp_sq = m * m;
        rhs = comp_sq << (2 * FRAC_BITS + 2);
        lo = 0;
        hi = longint'(1) << FRAC_BITS;
        while (lo < hi) begin
          mid = (lo + hi + 1) >>> 1;
          odd = 64'(2 * mid - 1);
          lhs = {128'd0, odd * odd};
          lhs = lhs * sum_sq;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        o[i] = (v[i] < 0) ? -lo : lo;
      end
    end
  endfunction

  function automatic void cross3(input longint a [3], input longint b [3],
                                 output longint r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint dot(input longint a [3], input longint b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic view_rows_t predict_view(input lav_pkg::coord_t eye [3],
                                              input lav_pkg::coord_t tgt [3],
                                              input lav_pkg::coord_t upv [3]);
    view_rows_t r;
    longint e [3], d [3], u_in [3], fwd [3], c [3], side [3], tu [3];
    longint one;
    one = longint'(1) << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      e[i]    = longint'(eye[i]);
      d[i]    = longint'(tgt[i]) - e[i];
      u_in[i] = longint'(upv[i]);
    end
    unit_vector(d, fwd);
    cross3(fwd, u_in, c);
    unit_vector(c, side);
    cross3(side, fwd, tu);
    for (int i = 0; i < 3; i++) begin
      tu[i] = round_frac(tu[i]);
      if (tu[i] > one) tu[i] = one;
      if (tu[i] < -one) tu[i] = -one;
    end
    for (int i = 0; i < 3; i++) begin
      r.unit_field[i]     = lav_pkg::unit_t'(side[i]);
      r.unit_field[3 + i] = lav_pkg::unit_t'(tu[i]);
      r.unit_field[6 + i] = lav_pkg::unit_t'(-fwd[i]);
    end
    r.shift[0] = lav_pkg::coord_t'(sat_word(-round_frac(dot(side, e))));
    r.shift[1] = lav_pkg::coord_t'(sat_word(-round_frac(dot(tu, e))));
    r.shift[2] = lav_pkg::coord_t'(sat_word(round_frac(dot(fwd, e))));
    return r;
  endfunction

  assign views_pending = view_queue.size();

  always @(posedge clk) begin
    view_rows_t want, got;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (pose.valid && pose.ready)
        view_queue.push_back(predict_view('{pose.eye_x, pose.eye_y, pose.eye_z},
                                          '{pose.target_x, pose.target_y, pose.target_z},
                                          '{pose.up_x, pose.up_y, pose.up_z}));
      if (view.valid && view.ready) begin
        got.unit_field = '{view.side_x, view.side_y, view.side_z, view.upaxis_x,
                           view.upaxis_y, view.upaxis_z, view.back_x, view.back_y,
                           view.back_z};
        got.shift = '{view.shift_x, view.shift_y, view.shift_z};
        if (view_queue.size() == 0) begin
          $error("view transfer with no pose outstanding");
          errs++;
        end else begin
          want = view_queue.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.unit_field[i] !== want.unit_field[i]) begin
              $error("%s: expected %0d, got %0d", unit_names[i], want.unit_field[i],
                     got.unit_field[i]);
              errs++;
            end
          for (int i = 0; i < 3; i++)
            if (got.shift[i] !== want.shift[i]) begin
              $error("%s: expected %0d, got %0d", shift_names[i], want.shift[i],
                     got.shift[i]);
              errs++;
            end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: dv/look_at_view_matrix_test.sv
// Testbench top for the look-at view matrix block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module look_at_view_matrix_test;
  localparam int              FRAC_BITS = lav_pkg::DEF_FRAC_BITS;
  localparam int              LATENCY   = 2 * FRAC_BITS + 20;
  localparam lav_pkg::coord_t ONE       = lav_pkg::coord_t'(1) <<< FRAC_BITS;
  localparam lav_pkg::coord_t CMAX      = 32'sh7fffffff;
  localparam lav_pkg::coord_t CMIN      = 32'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ready_idle_on = 1'b1;
  logic pose_idle_on = 1'b1;
  int   fail_count;
  int   views_pending;

  lav_pose_if pose_ch ();
  lav_view_if view_ch ();

  look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk  (clk),
    .rst  (rst),
    .pose (pose_ch),
    .view (view_ch)
  );

  look_at_view_matrix_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .pose          (pose_ch),
    .view          (view_ch),
    .fail_count    (fail_count),
    .views_pending (views_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    view_ch.ready = 1'b0;
    pose_ch.valid = 1'b0;
    {pose_ch.eye_x, pose_ch.eye_y, pose_ch.eye_z} = '0;
    {pose_ch.target_x, pose_ch.target_y, pose_ch.target_z} = '0;
    {pose_ch.up_x, pose_ch.up_y, pose_ch.up_z} = '0;
  end

  always @(posedge clk) begin
    view_ch.ready <= !ready_idle_on || ($urandom_range(0, 99) >= 19);
  end

  task automatic send_pose(input lav_pkg::coord_t ex, ey, ez, tx, ty, tz, ux, uy, uz);
    // idle each slot with the same odds
    while (pose_idle_on && $urandom_range(0, 99) < 19) begin
      pose_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pose_ch.valid <= 1'b1;
    {pose_ch.eye_x, pose_ch.eye_y, pose_ch.eye_z} <= {ex, ey, ez};
    {pose_ch.target_x, pose_ch.target_y, pose_ch.target_z} <= {tx, ty, tz};
    {pose_ch.up_x, pose_ch.up_y, pose_ch.up_z} <= {ux, uy, uz};
    @(posedge clk);
    while (!pose_ch.ready) @(posedge clk);
  endtask

  // Mix full-range words, small coordinates, extremes and zero.
  function automatic lav_pkg::coord_t pick_coord();
    case ($urandom_range(0, 5))
      0, 1:    return lav_pkg::coord_t'($urandom);
      2, 3:    return lav_pkg::coord_t'($urandom_range(0, 32'h00400000))
                      - lav_pkg::coord_t'(32'h00200000);
      4:       return ($urandom_range(0, 1)) ? CMAX : CMIN;
      default: return '0;
    endcase
  endfunction

  initial begin
    lav_pkg::coord_t e [3], t [3], u [3];
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed poses
    send_pose(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
    send_pose(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);  // target at eye
    send_pose(0, 0, 0, 0, 4 * ONE, 0, 0, ONE, 0);                        // up along view
    send_pose(0, 0, 0, 0, 0, -ONE, 0, 0, 0);                             // zero up
    send_pose(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pose(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_pose(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_pose(CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, ONE, 0);               // shift saturates
    send_pose(CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, 0, CMIN, 0);
    send_pose(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, ONE, 0, CMAX);
    send_pose(3 * ONE, 0, 0, 0, 0, 0, 0, 0, ONE);
    send_pose(0, 0, 0, 1, 1, 1, -1, 1, -1);
    send_pose(0, 0, 0, 3, 4, 0, 0, 0, 1);
    send_pose(-1, -1, -1, 0, 0, 0, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678);

    // hold off until the pipeline drains
    pose_ch.valid <= 1'b0;
    @(posedge clk);
    while (views_pending != 0) @(posedge clk);

    for (int n = 0; n < 1400; n++) begin
      ready_idle_on <= !(n >= 400 && n < 650);
      pose_idle_on  <= !(n >= 400 && n < 650);
      for (int i = 0; i < 3; i++) begin
        e[i] = pick_coord();
        t[i] = pick_coord();
        u[i] = pick_coord();
      end
      // occasionally aim the view along the up vector or at the eye itself
      if ($urandom_range(0, 19) == 0) t = e;
      else if ($urandom_range(0, 19) == 0) for (int i = 0; i < 3; i++) u[i] = t[i] - e[i];
      send_pose(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
    end
    pose_ch.valid <= 1'b0;
    ready_idle_on <= 1'b1;

    while (views_pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && views_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
